[hw/rtl/rva_pkg.sv]
// Package with shared types and constants of the restraint violation averager.
package rva_pkg;

  localparam int unsigned DistW   = 24;
  localparam int unsigned AvgW    = 32;
  localparam int unsigned AccW    = 48;
  localparam int unsigned SumW    = 64;
  localparam int unsigned TotW    = 34;

  typedef enum logic [3:0] {
    StIdle,
    StRead,
    StDiv3,
    StDiv6,
    StSquare,
    StUpdate,
    StRootI,
    StRootA,
    StOut
  } rva_state_e;

endpackage

[hw/rtl/rva_if.sv]
// Valid/ready channel interface used for the item, result and configuration beats.
interface rva_if #(
  parameter int unsigned Width = 1
) (
  input logic clk_i
);
  logic             valid;
  logic             ready;
  logic [Width-1:0] data;

  modport source (output valid, output data, input ready);
  modport sink   (input valid, input data, output ready);
endinterface

[hw/rtl/restraint_violation_r6_averager.sv]
// Top level of the restraint violation averager with r^-6 averaging.
//
// The block takes one atom-pair sample per input beat and returns exactly one
// result beat for it. Each sample is worked on alone: a single shared
// restoring divider, one quotient bit per cycle, forms r^-3 (three successive
// divisions of a 2^84 numerator by the distance) and r^-6 (six divisions of a
// 2^152 numerator), and a single 32 by 32 multiplier, reused, squares the
// averaged inverse cube. At a restraint end the inverse sixth root is found by
// a bit-serial search, one result bit per pass, where each pass raises the
// candidate to the sixth power on that same multiplier in 32-bit limbs. An
// item that does not close a restraint goes through the store read, the nine
// divider passes of 160 bits each, the squaring, the store update and the
// output stage. A zero distance skips the divisions. An item that closes a
// restraint adds the two roots, where every root bit takes a load step, six
// passes over seven limbs and a compare step. The input is not ready while an
// item is at work; it is ready again in the cycle after the output stage. The
// result register holds the finished beat until it is taken, and the next
// item may already be at work meanwhile; only when a new result is finished
// while the old one still waits does the output stage stall. The per-pair
// store is a memory that is cleared by a sweep over its MAX_PAIRS entries
// after reset, during which no item is accepted; configuration beats are taken
// at any time.
module restraint_violation_r6_averager
  import rva_pkg::*;
#(
  parameter int unsigned MAX_PAIRS = 1024
) (
  input  logic  clk_i,
  input  logic  rst_ni,
  rva_if.sink   in_i,
  rva_if.source out_o,
  rva_if.sink   cfg_i
);

  localparam int unsigned IdxW = 10;
  localparam int unsigned AdrW = (MAX_PAIRS > 1) ? $clog2(MAX_PAIRS) : 1;
  localparam int unsigned NumW = 160;
  localparam int unsigned LimbN = 6;

  // Input beat layout: idx, distance, avg, bound, rend, fend.
  logic [IdxW-1:0]  in_idx;
  logic [DistW-1:0] in_dist;
  logic [AvgW-1:0]  in_avg;
  logic [DistW-1:0] in_bound;
  logic             in_rend, in_fend;
  assign {in_idx, in_dist, in_avg, in_bound, in_rend, in_fend} = in_i.data;

  logic enable_q;
  assign cfg_i.ready = 1'b1;
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      enable_q <= 1'b1;
    end else if (cfg_i.valid) begin
      enable_q <= cfg_i.data[0];
    end
  end

  // Memory for the per-pair accumulators.
  logic [AccW-1:0] store_mem [MAX_PAIRS];
  logic [AccW-1:0] store_rd_q;
  logic            mem_we;
  logic [AdrW-1:0] mem_wa;
  logic [AccW-1:0] mem_wd;
  logic [AdrW-1:0] mem_ra;
  always_ff @(posedge clk_i) begin
    if (mem_we) begin
      store_mem[mem_wa] <= mem_wd;
    end
    store_rd_q <= store_mem[mem_ra];
  end

  rva_state_e state_q, state_d;
  logic [AdrW:0]      clr_q;
  logic               clr_busy;
  assign clr_busy = (clr_q < (AdrW+1)'(MAX_PAIRS));

  logic [IdxW-1:0]  idx_q;
  logic [DistW-1:0] dist_q, bound_q;
  logic [AvgW-1:0]  avg_q;
  logic             rend_q, fend_q;

  logic [SumW-1:0] sum_i_q, sum_a_q;
  logic [TotW-1:0] tot_i_q, tot_a_q;
  logic [AccW-1:0] acc_out_q;

  // Divider state: a 160-bit dividend, remainder, step counter, pass counter.
  logic [NumW-1:0]  num_q, num_d;
  logic [DistW:0]   rem_q, rem_d;
  logic [7:0]       bit_q, bit_d;
  logic [2:0]       pass_q, pass_d;
  logic [AccW-1:0]  r3_q, r3_d;

  // Shared 32x32 multiplier.
  logic [31:0] mul_a, mul_b;
  logic [63:0] mul_p;
  assign mul_p = 64'(mul_a) * 64'(mul_b);

  // Root search: candidate, limb vector of the product, limb and power counters.
  logic [DistW-1:0] root_q, root_d, cand;
  logic [4:0]       rbit_q, rbit_d;
  logic [31:0]      limb_q [LimbN+1];
  logic [31:0]      limb_d [LimbN+1];
  logic [2:0]       li_q, li_d;
  logic [2:0]       pw_q, pw_d;
  logic [31:0]      carry_q, carry_d;
  logic [DistW-1:0] ri_q, ri_d;

  assign cand = root_q | (DistW'(1) << rbit_q);

  // Fits test on the finished product: v^6 * s <= 2^152.
  logic fits;
  assign fits = (limb_q[6] == '0) && (limb_q[5] == '0) &&
                ((limb_q[4] < 32'h0100_0000) ||
                 ((limb_q[4] == 32'h0100_0000) &&
                  ({limb_q[3], limb_q[2], limb_q[1], limb_q[0]} == '0)));

  // Restoring division step on the current dividend bit.
  logic [DistW+1:0] trial;
  assign trial = {rem_q, num_q[NumW-1]} - {2'b0, dist_q};

  logic [SumW-1:0] root_sum;
  assign root_sum = (state_q == StRootI) ? sum_i_q : sum_a_q;

  logic [AccW:0]   acc_add;
  logic [SumW:0]   si_add, sa_add;
  logic [TotW:0]   ti_add, ta_add;
  logic [DistW-1:0] vi, va;

  logic [AccW-1:0]  o_acc;
  logic             o_rend, o_fend;
  logic [DistW-1:0] o_vi, o_va;
  logic [TotW-1:0]  o_ti, o_ta;
  logic             out_valid_q;

  assign out_o.valid = out_valid_q;
  assign out_o.data  = {o_acc, o_rend, o_vi, o_va, o_fend, o_ti, o_ta};
  assign in_i.ready  = (state_q == StIdle) && !clr_busy;

  logic in_fire, out_fire, out_free, idx_ok;
  assign in_fire  = in_i.valid && in_i.ready;
  assign out_fire = out_o.valid && out_o.ready;
  // The result register can take a new beat when it is empty or being emptied.
  assign out_free = !out_valid_q || out_o.ready;
  assign idx_ok   = (32'(idx_q) < MAX_PAIRS);

  assign vi = (ri_q > bound_q) ? ri_q - bound_q : '0;
  assign va = (root_q > bound_q) ? root_q - bound_q : '0;

  always_comb begin
    state_d = state_q;
    num_d   = num_q;
    rem_d   = rem_q;
    bit_d   = bit_q;
    pass_d  = pass_q;
    r3_d    = r3_q;
    root_d  = root_q;
    rbit_d  = rbit_q;
    li_d    = li_q;
    pw_d    = pw_q;
    carry_d = carry_q;
    ri_d    = ri_q;
    for (int i = 0; i <= LimbN; i++) begin
      limb_d[i] = limb_q[i];
    end
    mul_a  = avg_q;
    mul_b  = avg_q;
    mem_we = 1'b0;
    mem_wa = clr_q[AdrW-1:0];
    mem_wd = '0;
    mem_ra = AdrW'(idx_q);
    if (clr_busy) begin
      mem_we = 1'b1;
    end
    unique case (state_q)
      StIdle: begin
        if (in_fire) begin
          state_d = StRead;
        end
      end
      StRead: begin
        // Start the r^-3 divisions on 2^84.
        num_d   = NumW'(1) << 84;
        rem_d   = '0;
        bit_d   = '0;
        pass_d  = '0;
        state_d = (dist_q == '0) ? StSquare : StDiv3;
        if (dist_q == '0) begin
          r3_d = '0;
        end
      end
      StDiv3, StDiv6: begin
        num_d = {num_q[NumW-2:0], ~trial[DistW+1]};
        rem_d = trial[DistW+1] ? {rem_q[DistW-1:0], num_q[NumW-1]} : trial[DistW:0];
        bit_d = bit_q + 8'd1;
        if (bit_q == 8'(NumW - 1)) begin
          bit_d  = '0;
          rem_d  = '0;
          pass_d = pass_q + 3'd1;
          if (state_q == StDiv3 && pass_q == 3'd2) begin
            r3_d   = (num_d[NumW-1:AccW] != '0) ? '1 : num_d[AccW-1:0];
            num_d  = NumW'(1) << 152;
            pass_d = '0;
            state_d = StDiv6;
          end else if (state_q == StDiv6 && pass_q == 3'd5) begin
            state_d = StSquare;
          end else begin
            // Feed the quotient back unchanged as the next dividend.
            num_d = num_d;
          end
        end
      end
      StSquare: begin
        state_d = StUpdate;
      end
      StUpdate: begin
        if (idx_ok && enable_q && dist_q != '0) begin
          mem_we = 1'b1;
          mem_wa = AdrW'(idx_q);
          mem_wd = acc_add[AccW] ? '1 : acc_add[AccW-1:0];
        end
        root_d = '0;
        rbit_d = 5'(DistW - 1);
        li_d   = '0;
        pw_d   = '0;
        carry_d = '0;
        state_d = (rend_q || fend_q) ? StRootI : StOut;
      end
      StRootI, StRootA: begin
        // Multiply the limb vector by the candidate, one limb a cycle.
        if (pw_q == '0 && li_q == '0) begin
          limb_d[0] = root_sum[31:0];
          limb_d[1] = root_sum[63:32];
          for (int i = 2; i <= LimbN; i++) begin
            limb_d[i] = '0;
          end
          pw_d = 3'd1;
        end else if (pw_q <= 3'd6) begin
          mul_a = limb_q[li_q];
          mul_b = 32'(cand);
          limb_d[li_q] = mul_p[31:0] + carry_q;
          carry_d = mul_p[63:32] + 32'((33'(mul_p[31:0]) + 33'(carry_q)) >> 32);
          li_d = li_q + 3'd1;
          if (li_q == 3'(LimbN)) begin
            li_d = '0;
            carry_d = '0;
            pw_d = pw_q + 3'd1;
          end
        end else begin
          if (fits && root_sum != '0) begin
            root_d = cand;
          end
          pw_d = '0;
          li_d = '0;
          rbit_d = rbit_q - 5'd1;
          if (rbit_q == '0) begin
            if (state_q == StRootI) begin
              ri_d    = (fits && root_sum != '0) ? cand : root_q;
              root_d  = '0;
              rbit_d  = 5'(DistW - 1);
              state_d = StRootA;
            end else begin
              state_d = StOut;
            end
          end
        end
      end
      StOut: begin
        if (out_free) begin
          state_d = StIdle;
        end
      end
      default: begin
        state_d = StIdle;
      end
    endcase
  end

  // Quotient overflow beyond 64 bits saturates r^-6.
  logic [SumW-1:0] r6;
  assign r6 = (num_q[NumW-1:SumW] != '0) ? '1 : num_q[SumW-1:0];

  assign acc_add = {1'b0, store_rd_q} + {1'b0, r3_q};
  assign si_add  = {1'b0, sum_i_q} + {1'b0, r6};
  assign sa_add  = {1'b0, sum_a_q} + {1'b0, mul_p};
  assign ti_add  = {1'b0, tot_i_q} + (TotW+1)'(vi);
  assign ta_add  = {1'b0, tot_a_q} + (TotW+1)'(va);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= StIdle;
      clr_q       <= '0;
      out_valid_q <= 1'b0;
      sum_i_q     <= '0;
      sum_a_q     <= '0;
      tot_i_q     <= '0;
      tot_a_q     <= '0;
    end else begin
      state_q <= state_d;
      if (clr_busy) begin
        clr_q <= clr_q + 1'b1;
      end
      if (state_q == StSquare) begin
        if (dist_q != '0) begin
          sum_i_q <= si_add[SumW] ? '1 : si_add[SumW-1:0];
        end
        sum_a_q <= sa_add[SumW] ? '1 : sa_add[SumW-1:0];
      end
      if (state_q == StOut && out_free) begin
        out_valid_q <= 1'b1;
        if (rend_q || fend_q) begin
          sum_i_q <= '0;
          sum_a_q <= '0;
          if (fend_q) begin
            tot_i_q <= '0;
            tot_a_q <= '0;
          end else begin
            tot_i_q <= ti_add[TotW] ? '1 : ti_add[TotW-1:0];
            tot_a_q <= ta_add[TotW] ? '1 : ta_add[TotW-1:0];
          end
        end
      end else if (out_fire) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    num_q   <= num_d;
    rem_q   <= rem_d;
    bit_q   <= bit_d;
    pass_q  <= pass_d;
    r3_q    <= r3_d;
    root_q  <= root_d;
    rbit_q  <= rbit_d;
    li_q    <= li_d;
    pw_q    <= pw_d;
    carry_q <= carry_d;
    ri_q    <= ri_d;
    for (int i = 0; i <= LimbN; i++) begin
      limb_q[i] <= limb_d[i];
    end
    if (in_fire) begin
      idx_q   <= in_idx;
      dist_q  <= in_dist;
      avg_q   <= in_avg;
      bound_q <= in_bound;
      rend_q  <= in_rend;
      fend_q  <= in_fend;
    end
    if (state_q == StUpdate) begin
      acc_out_q <= !idx_ok ? '0 :
                   (enable_q && dist_q != '0) ? (acc_add[AccW] ? '1 : acc_add[AccW-1:0])
                                              : store_rd_q;
    end
    if (state_q == StOut && out_free) begin
      o_acc  <= acc_out_q;
      o_rend <= rend_q || fend_q;
      o_fend <= fend_q;
      o_vi   <= (rend_q || fend_q) ? vi : '0;
      o_va   <= (rend_q || fend_q) ? va : '0;
      o_ti   <= fend_q ? (ti_add[TotW] ? '1 : ti_add[TotW-1:0]) : '0;
      o_ta   <= fend_q ? (ta_add[TotW] ? '1 : ta_add[TotW-1:0]) : '0;
    end
  end

  // A waiting result beat stays valid and unchanged until it is taken.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_o.valid && !out_o.ready |=> out_o.valid && $stable(out_o.data))
    else $error("pending result dropped or changed");
  // A result appears only after the output state.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(out_valid_q) |-> $past(state_q) == StOut)
    else $error("result raised outside the output state");
  // Nothing is accepted during the clearing sweep.
  assert property (@(posedge clk_i) disable iff (!rst_ni) clr_busy |-> !in_i.ready)
    else $error("ready during the store clearing sweep");

endmodule

[test/tb_restraint_violation_r6_averager.sv]
// Self-checking testbench of the restraint violation averager with r^-6 averaging.
module tb_restraint_violation_r6_averager;
  timeunit 1ns;
  timeprecision 1ps;

  import rva_pkg::*;

  // One input beat: a single atom-pair sample, first field in the top bits.
  typedef struct packed {
    logic [9:0]      pair_index;
    logic [DistW-1:0] distance;
    logic [AvgW-1:0]  avg_inv_cube;
    logic [DistW-1:0] upper_bound;
    logic            last_in_restraint;
    logic            last_in_frame;
  } sample_t;

  // One result beat.
  typedef struct packed {
    logic [AccW-1:0]  pair_accumulated;
    logic             restraint_done;
    logic [DistW-1:0] instant_violation;
    logic [DistW-1:0] average_violation;
    logic             frame_done;
    logic [TotW-1:0]  frame_instant_total;
    logic [TotW-1:0]  frame_average_total;
  } verdict_t;

  typedef enum logic [1:0] {
    OpSample,
    OpEnable,
    OpDrain
  } plan_kind_e;

  typedef struct {
    plan_kind_e kind;
    sample_t    sample;
    logic       enable;
  } plan_entry_t;

  localparam int unsigned NumPairs   = 1024;
  localparam int unsigned RandomGoal = 1530;
  localparam int unsigned SettleCyc  = 30;
  // The limit leaves a wide margin for the slowest items with a restraint end,
  // long stalls on both sides and the clearing sweep.
  localparam longint unsigned CycleLimit = 60_000_000;

  logic clk_i = 1'b0;
  logic rst_ni;

  always begin
    #2 clk_i = 1'b1;
    #2 clk_i = 1'b0;
  end

  rva_if #(.Width($bits(sample_t)))  in_if  (clk_i);
  rva_if #(.Width($bits(verdict_t))) out_if (clk_i);
  rva_if #(.Width(1))                cfg_if (clk_i);

  restraint_violation_r6_averager #(
    .MAX_PAIRS(NumPairs)
  ) dut (
    .clk_i (clk_i),
    .rst_ni(rst_ni),
    .in_i  (in_if),
    .out_o (out_if),
    .cfg_i (cfg_if)
  );

  // Own copy of the block's state, advanced once per accepted sample beat.
  logic [AccW-1:0] pair_store [NumPairs];
  logic [SumW-1:0] inv_sixth_sum;
  logic [SumW-1:0] avg_sq_sum;
  logic [TotW-1:0] frame_inst_acc;
  logic [TotW-1:0] frame_avg_acc;
  logic            accum_enable;

  plan_entry_t plan[$];
  verdict_t    expected_verdicts[$];
  int unsigned error_count = 0;
  longint unsigned cycle_count = 0;

  // floor(2^84 / d^3) or floor(2^152 / d^6), saturated to 48 or 64 bits.
  function automatic logic [SumW-1:0] inv_power(logic [DistW-1:0] d, bit sixth);
    logic [159:0] num, den, quo, lim;
    den = 160'd1;
    for (int k = 0; k < (sixth ? 6 : 3); k++) den = den * d;
    num = sixth ? (160'd1 << 152) : (160'd1 << 84);
    lim = sixth ? ((160'd1 << 64) - 1) : ((160'd1 << 48) - 1);
    quo = num / den;
    return (quo > lim) ? lim[SumW-1:0] : quo[SumW-1:0];
  endfunction

  // Largest Q4.20 value v with v^6 * s <= 2^152; an empty sum gives zero.
  function automatic logic [DistW-1:0] inv_sixth_root(logic [SumW-1:0] s);
    logic [24:0]  lo, hi, mid;
    logic [255:0] p;
    if (s == '0) return '0;
    lo = '0;
    hi = 25'hFFFFFF;
    while (lo < hi) begin
      mid = lo + (hi - lo + 1) / 2;
      p = mid;
      for (int k = 0; k < 5; k++) p = p * mid;
      p = p * s;
      if (p <= (256'd1 << 152)) lo = mid;
      else hi = mid - 1;
    end
    return lo[DistW-1:0];
  endfunction

  function automatic logic [SumW-1:0] sat_add64(logic [SumW-1:0] a, logic [SumW-1:0] b);
    logic [SumW:0] r;
    r = {1'b0, a} + b;
    return r[SumW] ? '1 : r[SumW-1:0];
  endfunction

  function automatic logic [TotW-1:0] sat_add34(logic [TotW-1:0] a, logic [DistW-1:0] b);
    logic [TotW:0] r;
    r = {1'b0, a} + b;
    return r[TotW] ? '1 : r[TotW-1:0];
  endfunction

  // Works out the result beat that a sample causes and queues it.
  task automatic forecast_verdict(sample_t s);
    verdict_t        v;
    logic [AccW:0]   acc;
    logic [SumW-1:0] r3;
    logic [DistW-1:0] ri, ra;
    logic            closes;
    v = '0;
    if (accum_enable && s.distance != '0) begin
      r3 = inv_power(s.distance, 1'b0);
      acc = {1'b0, pair_store[s.pair_index]} + {1'b0, r3[AccW-1:0]};
      pair_store[s.pair_index] = acc[AccW] ? '1 : acc[AccW-1:0];
    end
    v.pair_accumulated = pair_store[s.pair_index];
    if (s.distance != '0) inv_sixth_sum = sat_add64(inv_sixth_sum, inv_power(s.distance, 1'b1));
    avg_sq_sum = sat_add64(avg_sq_sum, SumW'(s.avg_inv_cube) * SumW'(s.avg_inv_cube));
    // A frame end always closes the restraint that is open.
    closes = s.last_in_restraint | s.last_in_frame;
    if (closes) begin
      ri = inv_sixth_root(inv_sixth_sum);
      ra = inv_sixth_root(avg_sq_sum);
      v.restraint_done    = 1'b1;
      v.instant_violation = (ri > s.upper_bound) ? ri - s.upper_bound : '0;
      v.average_violation = (ra > s.upper_bound) ? ra - s.upper_bound : '0;
      frame_inst_acc = sat_add34(frame_inst_acc, v.instant_violation);
      frame_avg_acc  = sat_add34(frame_avg_acc, v.average_violation);
      inv_sixth_sum  = '0;
      avg_sq_sum     = '0;
    end
    if (s.last_in_frame) begin
      v.frame_done          = 1'b1;
      v.frame_instant_total = frame_inst_acc;
      v.frame_average_total = frame_avg_acc;
      frame_inst_acc = '0;
      frame_avg_acc  = '0;
    end
    expected_verdicts.push_back(v);
  endtask

  // Idle lengths: mostly none or short, now and then a long one.
  function automatic int unsigned idle_len();
    int unsigned r;
    r = $urandom_range(0, 99);
    if (r < 55) return 0;
    if (r < 90) return $urandom_range(1, 4);
    return $urandom_range(10, 150);
  endfunction

  function automatic void plan_sample(sample_t s);
    plan_entry_t e;
    e.kind = OpSample;
    e.sample = s;
    e.enable = 1'b0;
    plan.push_back(e);
  endfunction

  // Waits for every outstanding result, then writes the enable register.
  function automatic void plan_enable(logic en);
    plan_entry_t e;
    e.kind = OpDrain;
    e.sample = '0;
    e.enable = 1'b0;
    plan.push_back(e);
    e.kind = OpEnable;
    e.enable = en;
    plan.push_back(e);
  endfunction

  function automatic sample_t make_sample(logic [9:0] idx, logic [DistW-1:0] d,
                                          logic [AvgW-1:0] avg, logic [DistW-1:0] ub,
                                          logic rend, logic fend);
    sample_t s;
    s.pair_index = idx;
    s.distance = d;
    s.avg_inv_cube = avg;
    s.upper_bound = ub;
    s.last_in_restraint = rend;
    s.last_in_frame = fend;
    return s;
  endfunction

  // A plausible sample: pair distances of about 0.1 to 2 nm, an averaged
  // inverse cube near what such distances give, and a bound around 0.2 to 1 nm.
  // Roughly one in ten distances, averages and bounds is drawn from its whole range instead.
  function automatic sample_t random_sample();
    sample_t s;
    s.pair_index = $urandom_range(0, 99) < 70 ? 10'($urandom_range(0, 31))
                                              : 10'($urandom_range(0, NumPairs - 1));
    case ($urandom_range(0, 19))
      0:       s.distance = '0;
      1, 2:    s.distance = DistW'($urandom);
      default: s.distance = DistW'($urandom_range(100_000, 2_100_000));
    endcase
    case ($urandom_range(0, 19))
      0:       s.avg_inv_cube = '0;
      1, 2:    s.avg_inv_cube = $urandom;
      default: s.avg_inv_cube = $urandom_range(8_000, 70_000_000);
    endcase
    s.upper_bound = $urandom_range(0, 9) == 0 ? DistW'($urandom)
                                              : DistW'($urandom_range(200_000, 1_100_000));
    s.last_in_restraint = 1'b0;
    s.last_in_frame = 1'b0;
    return s;
  endfunction

  // Stimulus, clock counting and the final verdict.
  initial begin
    int unsigned made, left, phase_end;
    sample_t     s;
    in_if.valid   = 1'b0;
    in_if.data    = '0;
    cfg_if.valid  = 1'b0;
    cfg_if.data   = '0;
    out_if.ready  = 1'b0;
    rst_ni        = 1'b0;
    accum_enable  = 1'b1;
    inv_sixth_sum = '0;
    avg_sq_sum    = '0;
    frame_inst_acc = '0;
    frame_avg_acc  = '0;
    foreach (pair_store[i]) pair_store[i] = '0;

    // Directed part. The register is written at once, to its reset value.
    plan_enable(1'b1);
    // Shortest distance saturates both powers; the root then sits near zero.
    plan_sample(make_sample(10'd0, 24'd1, '1, '0, 1'b1, 1'b0));
    // Longest distance, largest bound and index at the top of the store.
    plan_sample(make_sample(10'd1023, '1, '0, '1, 1'b1, 1'b0));
    // Zero distance with zero average gives an empty sum and no violation.
    plan_sample(make_sample(10'd5, '0, '0, '0, 1'b1, 1'b0));
    // A three-sample restraint over pairs 7 and 8 with realistic values and a zero bound.
    plan_sample(make_sample(10'd7, 24'd524288, 32'd524288, '0, 1'b0, 1'b0));
    plan_sample(make_sample(10'd8, 24'd1048576, 32'd65536, '0, 1'b0, 1'b0));
    plan_sample(make_sample(10'd7, 24'd314573, 32'd2_200_000, '0, 1'b1, 1'b0));
    // Frame end without restraint end closes the open restraint too.
    plan_sample(make_sample(10'd9, 24'd400000, 32'd1_000_000, 24'd100000, 1'b0, 1'b1));
    // Same pair twice in a row so its accumulator builds up.
    plan_sample(make_sample(10'd1, 24'd2, 32'd1, 24'd1, 1'b0, 1'b0));
    plan_sample(make_sample(10'd1, 24'd2, 32'hFFFF_0000, 24'd1, 1'b1, 1'b1));
    // With accumulation off the store only reads back.
    plan_enable(1'b0);
    plan_sample(make_sample(10'd7, 24'd524288, 32'd524288, 24'd300000, 1'b1, 1'b0));
    plan_sample(make_sample(10'd1023, 24'd1, '1, 24'hAAAAAA, 1'b0, 1'b0));
    plan_sample(make_sample(10'h2AA, 24'h555555, 32'h5555_5555, 24'h555555, 1'b1, 1'b1));
    plan_enable(1'b1);
    plan_sample(make_sample(10'h155, 24'hAAAAAA, 32'hAAAA_AAAA, 24'h000001, 1'b1, 1'b1));

    // Random part: frames of whole restraints, a few broken ones, in phases
    // separated by register writes.
    made = 0;
    while (made < RandomGoal) begin
      phase_end = made + $urandom_range(200, 400);
      while (made < phase_end && made < RandomGoal) begin
        left = $urandom_range(0, 7) == 0 ? $urandom_range(1, 3) : $urandom_range(3, 12);
        for (int k = 0; k < left; k++) begin
          s = random_sample();
          s.last_in_restraint = (k == left - 1);
          if ($urandom_range(0, 29) == 0) s.last_in_restraint = $urandom_range(0, 1);
          if (k == left - 1 && $urandom_range(0, 3) == 0) begin
            s.last_in_frame = 1'b1;
            if ($urandom_range(0, 3) == 0) s.last_in_restraint = 1'b0;
          end
          plan_sample(s);
          made++;
        end
      end
      plan_enable($urandom_range(0, 2) != 0);
    end
    plan_enable(1'b1);

    repeat (9) @(posedge clk_i);
    rst_ni <= 1'b1;

    wait (plan.size() == 0 && !in_if.valid && !cfg_if.valid && expected_verdicts.size() == 0);
    // Let any stray beat show up before the verdict is given.
    repeat (200) @(posedge clk_i);
    if (expected_verdicts.size() != 0) begin
      $display("%0t: %0d expected results never arrived", $realtime, expected_verdicts.size());
      error_count++;
    end
    if (error_count == 0) begin
      $display("Testbench completed without errors");
    end else begin
      $display("Testbench completed WITH ERRORS");
    end
    $finish;
  end

  always @(posedge clk_i) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count >= CycleLimit) begin
      $display("%0t: timeout after %0d cycles", $realtime, cycle_count);
      $display("Testbench completed WITH ERRORS");
      $finish;
    end
  end

  // Driver: takes entries off the plan, one beat at a time, with idle gaps.
  // A drain entry holds the sender back until every result has come back.
  int unsigned send_gap = 0;
  int unsigned settle   = SettleCyc;
  bit          calm     = 1'b0;

  always @(posedge clk_i) begin : drive_p
    logic nv, cv;
    nv = in_if.valid;
    cv = cfg_if.valid;
    if (rst_ni) begin
      if (in_if.valid && in_if.ready) begin
        forecast_verdict(sample_t'(in_if.data));
        nv = 1'b0;
      end
      if (cfg_if.valid && cfg_if.ready) begin
        accum_enable = cfg_if.data[0];
        cv = 1'b0;
      end
      if ($urandom_range(0, 199) == 0) calm = !calm;
      if (!nv && !cv) begin
        if (send_gap > 0) begin
          send_gap--;
        end else if (plan.size() > 0) begin
          case (plan[0].kind)
            OpSample: begin
              nv = 1'b1;
              in_if.data <= plan[0].sample;
              void'(plan.pop_front());
              send_gap = calm ? 0 : idle_len();
            end
            OpEnable: begin
              cv = 1'b1;
              cfg_if.data <= plan[0].enable;
              void'(plan.pop_front());
            end
            default: begin
              if (expected_verdicts.size() != 0) begin
                settle = SettleCyc;
              end else if (settle > 0) begin
                settle--;
              end else begin
                settle = SettleCyc;
                void'(plan.pop_front());
              end
            end
          endcase
        end
      end
    end
    in_if.valid  <= nv;
    cfg_if.valid <= cv;
  end

  task automatic compare_field(string name, logic [63:0] exp_v, logic [63:0] act_v);
    if (exp_v !== act_v) begin
      $display("%0t: %s mismatch, expected %0h, actual %0h", $realtime, name, exp_v, act_v);
      error_count++;
    end
  endtask

  // Monitor: stalls the result channel at random and checks each beat
  // against the oldest expectation.
  int unsigned recv_stall = 0;

  always @(posedge clk_i) begin : watch_p
    verdict_t act, exp_v;
    logic     nr;
    nr = out_if.ready;
    if (rst_ni) begin
      if (out_if.valid && out_if.ready) begin
        act = verdict_t'(out_if.data);
        if (expected_verdicts.size() == 0) begin
          $display("%0t: unexpected result beat %0h", $realtime, act);
          error_count++;
        end else begin
          exp_v = expected_verdicts.pop_front();
          compare_field("pair_accumulated", exp_v.pair_accumulated, act.pair_accumulated);
          compare_field("restraint_done", exp_v.restraint_done, act.restraint_done);
          compare_field("instant_violation", exp_v.instant_violation, act.instant_violation);
          compare_field("average_violation", exp_v.average_violation, act.average_violation);
          compare_field("frame_done", exp_v.frame_done, act.frame_done);
          compare_field("frame_instant_total", exp_v.frame_instant_total,
                        act.frame_instant_total);
          compare_field("frame_average_total", exp_v.frame_average_total,
                        act.frame_average_total);
        end
        recv_stall = calm ? 0 : idle_len();
        nr = (recv_stall == 0);
      end else if (!out_if.ready) begin
        if (recv_stall > 0) recv_stall--;
        nr = (recv_stall == 0);
      end
    end
    out_if.ready <= nr;
  end

endmodule

[filelist.f]
hw/rtl/rva_pkg.sv
hw/rtl/rva_if.sv
hw/rtl/restraint_violation_r6_averager.sv
test/tb_restraint_violation_r6_averager.sv
